// ----- sv/ttl_fifo_negative_cache_assert.svh -----
// Assertion macros shared by the checkers of the negative cache.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TTL_FIFO_NEGATIVE_CACHE_ASSERT_SVH
`define TTL_FIFO_NEGATIVE_CACHE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define TFNC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfnc assertion failed");

// Antecedent implies consequent in the next cycle.
`define TFNC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfnc assertion failed");

`endif

// ----- sv/tfnc_pkg.sv -----
// Shared types and constants of the TTL negative cache.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfnc_pkg;

  localparam int OP_W       = 2;
  localparam int KEY_PORT_W = 64;
  localparam int TIME_W     = 32;
  localparam int TTL_W      = 31;

  localparam logic [TTL_W-1:0] TTL_RESET = 31'd1000;

  localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ----- sv/ttl_fifo_negative_cache.sv -----
// Check: the entry memory is scanned at one read per cycle until the first valid key match
// or the last entry, then the result register loads (it waits while an earlier result stalls).
// Insert, clear, disabled and unused items skip the scan. One item in flight at a time; the next
// item is accepted the cycle after the result loads.
// Reset (rst_n, synchronous, active low): all entries invalid, pointer 0, ttl 1000.
// Entry keys and stamps live in one memory and are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ttl_fifo_negative_cache #(
  parameter int ENTRIES   = 32,
  parameter int KEY_WIDTH = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [tfnc_pkg::OP_W-1:0]        in_operation,
  input  wire  [tfnc_pkg::KEY_PORT_W-1:0]  in_key,
  input  wire  [tfnc_pkg::TIME_W-1:0]      in_now_ms,
  input  wire                              in_clock_ok,
  input  wire                              in_key_too_long,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_hit,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [tfnc_pkg::TTL_W-1:0]       cfg_ttl_ms
);
  import tfnc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int MW = KEY_WIDTH + TIME_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  state_t              state_r, state_nxt;
  logic [TTL_W-1:0]    ttl_r;
  logic [AW-1:0]       ptr_r;
  logic [ENTRIES-1:0]  valid_r;
  logic [AW-1:0]       scan_addr_r;
  logic                issue_done_r;
  logic                cmp_vld_r;
  logic [AW-1:0]       cmp_idx_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [TIME_W-1:0]   now_r;
  logic                hit_r;
  logic                out_valid_r;
  logic                out_hit_r;

  logic [MW-1:0]       mem [ENTRIES];
  logic [MW-1:0]       rd_data_r;

  logic                accept;
  logic                is_check, is_insert, is_clear;
  logic                chk_active, ins_active;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [TIME_W-1:0]   rd_stamp;
  logic [TIME_W-1:0]   age;
  logic                match, fresh, scan_end, out_load;
  logic [AW-1:0]       ptr_next;

  assign accept     = in_valid && in_ready;
  assign is_check   = (in_operation == OP_CHECK);
  assign is_insert  = (in_operation == OP_INSERT);
  assign is_clear   = (in_operation == OP_CLEAR);
  assign chk_active = (ttl_r != '0) && in_clock_ok && !in_key_too_long;
  assign ins_active = (ttl_r != '0) && !in_key_too_long;
  assign ptr_next   = (ptr_r == LAST_IDX) ? '0 : ptr_r + AW'(1);

  assign rd_key   = rd_data_r[MW-1:TIME_W];
  assign rd_stamp = rd_data_r[TIME_W-1:0];
  assign age      = now_r - rd_stamp;
  assign fresh    = (age <= {1'b0, ttl_r});
  // first valid match ends the scan, whether fresh or stale
  assign match    = cmp_vld_r && valid_r[cmp_idx_r] && (rd_key == key_r);
  assign scan_end = match || (cmp_vld_r && (cmp_idx_r == LAST_IDX));
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (is_check && chk_active) ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_end) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cfg_ready = 1'b1;
    out_valid = out_valid_r;
    out_hit   = out_hit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ttl_r        <= TTL_RESET;
      ptr_r        <= '0;
      valid_r      <= '0;
      scan_addr_r  <= '0;
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) ttl_r <= cfg_ttl_ms;

      if (accept) begin
        scan_addr_r  <= '0;
        issue_done_r <= 1'b0;
        if (is_insert && ins_active) begin
          valid_r[ptr_r] <= in_clock_ok;
          ptr_r          <= ptr_next;
        end else if (is_clear) begin
          valid_r <= '0;
          ptr_r   <= '0;
        end
      end

      if (state_r == ST_SCAN) begin
        cmp_vld_r <= !issue_done_r && !scan_end;
        if (!issue_done_r) begin
          if (scan_addr_r == LAST_IDX) issue_done_r <= 1'b1;
          else scan_addr_r <= scan_addr_r + AW'(1);
        end
        if (match && !fresh) valid_r[cmp_idx_r] <= 1'b0;
      end else begin
        cmp_vld_r <= 1'b0;
      end

      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_addr_r;
    if (accept) begin
      key_r <= in_key[KEY_WIDTH-1:0];
      now_r <= in_now_ms;
      hit_r <= 1'b0;
    end else if (state_r == ST_SCAN && match) begin
      hit_r <= fresh;
    end
    if (out_load) out_hit_r <= hit_r;
  end

  // entry memory: key and stamp per entry, one write and one read port
  always_ff @(posedge clk) begin
    if (accept && is_insert && ins_active) begin
      mem[ptr_r] <= {in_key[KEY_WIDTH-1:0], in_now_ms};
    end
    rd_data_r <= mem[scan_addr_r];
  end

endmodule

`default_nettype wire

// ----- sv/tfnc_checker.sv -----
// Port-level checks of the TTL negative cache, bound to the top level.
// Uses the macros of ttl_fifo_negative_cache_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ttl_fifo_negative_cache_assert.svh"

module tfnc_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire out_hit
);

  // a stalled result holds
  `TFNC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hit))

  // one item at a time: the input closes right after an accept
  `TFNC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // a new result appears only as the item in flight retires
  `TFNC_ASSERT_SAME(a_result_retires, $rose(out_valid), $past(!in_ready))

endmodule

bind ttl_fifo_negative_cache tfnc_checker u_tfnc_checker (.*);

`default_nettype wire
